FILE: rtl/scb_pkg.sv
`default_nettype none
package scb_pkg;

  // Store and display geometry
  localparam int BUF_LINES  = 5;
  localparam int DISP_LINES = 2;
  localparam int DISP_COLS  = 16;
  localparam int TOP_MAX    = BUF_LINES - DISP_LINES;

  localparam int ROW_W   = $clog2(BUF_LINES);
  localparam int COL_W   = $clog2(DISP_COLS);
  localparam int LEN_W   = $clog2(DISP_COLS + 1);
  localparam int VIEW_W  = (TOP_MAX > 0) ? $clog2(TOP_MAX + 1) : 1;
  localparam int DROW_W  = (DISP_LINES > 1) ? $clog2(DISP_LINES) : 1;
  localparam int STORE_DEPTH = BUF_LINES * DISP_COLS;
  localparam int ADDR_W  = $clog2(STORE_DEPTH);

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef enum logic [1:0] {
    OP_PRINT   = 2'd0,
    OP_MOVE    = 2'd1,
    OP_REFRESH = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_POS   = 2'd1,
    KIND_CHAR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CMD_PRINT,
    CMD_NEWLINE,
    CMD_BACK,
    CMD_FWD,
    CMD_REFRESH
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] ch;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     avail;
    q_entry_t entry;
  } q_head_t;

endpackage
`default_nettype wire

FILE: rtl/scrollback_text_console_unit.sv
// Scrollback text console for a character display.
//
// Input channel (in_valid / in_stall): one item per handshake carrying an
// opcode, a character and a signed direction. Print items write into the
// bottom line of a five-line scrollback store; newline or a full line scrolls
// the store. Move items shift the two-line view window. Refresh items produce
// a run of result items: clear, then per visible row a set-position followed
// by the row's characters; the final item of the run has out_last set.
// Output channel (out_valid / out_stall): results leave from a register.
// Accepted items pass through a two-entry command queue, so input is taken
// while a result waits. A refresh emits its results one per cycle while
// out_stall is low. The walk of the character store through its read port
// sets that one-per-cycle pace. in_stall rises only when the command queue
// is full. A stalled result holds its value. Reset clears the store (line
// lengths to zero), puts the view on the newest lines and empties the queue;
// no clearing pass is needed.
`default_nettype none
module scrollback_text_console_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [7:0]        in_character,
  input  wire logic signed [1:0] in_direction,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_kind,
  output logic                   out_row,
  output logic [3:0]             out_column,
  output logic [7:0]             out_glyph,
  output logic                   out_last
);
  import scb_pkg::*;

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  // Classify items and drop those that change nothing
  scb_front u_front (
    .in_valid     (in_valid),
    .in_opcode    (in_opcode),
    .in_character (in_character),
    .in_direction (in_direction),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .q_push       (q_push)
  );

  // Hold commands while the back end is busy with a refresh
  scb_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_head (q_head)
  );

  // Update the store and view, walk the visible rows on refresh
  scb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_row    (out_row),
    .out_column (out_column),
    .out_glyph  (out_glyph),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire

FILE: rtl/scb_ram.sv
`default_nettype none
module scb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/scb_front.sv
`default_nettype none
module scb_front (
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [7:0]        in_character,
  input  wire logic signed [1:0] in_direction,
  output logic                   in_stall,
  input  wire logic              q_full,
  output scb_pkg::q_push_t       q_push
);
  import scb_pkg::*;

  logic useful;
  cmd_t cmd;

  // Sort each item into a command; drop items that change nothing
  always_comb begin
    useful = 1'b0;
    cmd    = CMD_PRINT;
    case (opcode_t'(in_opcode))
      OP_PRINT: begin
        if (in_character == CH_NEWLINE) begin
          useful = 1'b1;
          cmd    = CMD_NEWLINE;
        end else if (in_character != CH_NUL) begin
          useful = 1'b1;
          cmd    = CMD_PRINT;
        end
      end
      OP_MOVE: begin
        if (in_direction < 2'sd0) begin
          useful = 1'b1;
          cmd    = CMD_BACK;
        end else if (in_direction > 2'sd0) begin
          useful = 1'b1;
          cmd    = CMD_FWD;
        end
      end
      OP_REFRESH: begin
        useful = 1'b1;
        cmd    = CMD_REFRESH;
      end
      default: begin
        useful = 1'b0;
      end
    endcase
  end

  assign in_stall       = q_full;
  assign q_push.push     = in_valid && !q_full && useful;
  assign q_push.entry.cmd = cmd;
  assign q_push.entry.ch  = in_character;

endmodule
`default_nettype wire

FILE: rtl/scb_queue.sv
`default_nettype none
module scb_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire scb_pkg::q_push_t q_push,
  output logic                  q_full,
  input  wire logic             q_pop,
  output scb_pkg::q_head_t      q_head
);
  import scb_pkg::*;

  q_entry_t             ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_pop;

  assign q_full       = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_head.avail = (count_r != '0);
  assign q_head.entry = ent_r[rd_ptr_r];
  assign do_pop       = q_pop && q_head.avail;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push.push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push.push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!q_push.push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (q_push.push) begin
      ent_r[wr_ptr_r] <= q_push.entry;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/scb_back.sv
`default_nettype none
module scb_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire scb_pkg::q_head_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            out_kind,
  output logic                  out_row,
  output logic [3:0]            out_column,
  output logic [7:0]            out_glyph,
  output logic                  out_last
);
  import scb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_POS,
    S_CHAR
  } state_t;

  state_t              state_r, state_nxt;
  logic [ROW_W-1:0]    head_r, head_nxt;
  logic [VIEW_W-1:0]   view_r, view_nxt;
  logic [LEN_W-1:0]    len_r [BUF_LINES];
  logic [LEN_W-1:0]    len_nxt [BUF_LINES];
  logic [DROW_W-1:0]   drow_r, drow_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [LEN_W-1:0]    rlen_r, rlen_nxt;
  logic [ADDR_W-1:0]   rbase_r, rbase_nxt;

  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic                out_row_r, out_row_nxt;
  logic [3:0]          out_col_r, out_col_nxt;
  logic [7:0]          out_glyph_r, out_glyph_nxt;
  logic                out_last_r, out_last_nxt;

  logic                wr_en, rd_en;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [7:0]          wr_data, rd_data;

  logic [ROW_W-1:0]    bottom, head_inc, src, phys;
  logic [ROW_W:0]      phys_sum;
  logic [LEN_W-1:0]    row_len;
  logic [ADDR_W-1:0]   row_base;
  logic                out_free, last_row, col_last, emit_last;

  scb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Ring pointer: head is the oldest line, the one before it the bottom line
  assign bottom   = (head_r == '0) ? ROW_W'(BUF_LINES - 1) : head_r - 1'b1;
  assign head_inc = (head_r == ROW_W'(BUF_LINES - 1)) ? '0 : head_r + 1'b1;
  assign src      = ROW_W'(view_r) + ROW_W'(drow_r);
  assign phys_sum = {1'b0, head_r} + {1'b0, src};
  assign phys     = (phys_sum >= (ROW_W + 1)'(BUF_LINES)) ?
                    ROW_W'(phys_sum - (ROW_W + 1)'(BUF_LINES)) : ROW_W'(phys_sum);
  assign row_len  = len_r[phys];
  assign row_base = ADDR_W'(phys) * ADDR_W'(DISP_COLS);

  assign out_free = !out_valid_r || !out_stall;
  assign last_row = (drow_r == DROW_W'(DISP_LINES - 1));
  assign col_last = ((LEN_W'(col_r) + 1'b1) == rlen_r);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    view_nxt      = view_r;
    len_nxt       = len_r;
    drow_nxt      = drow_r;
    col_nxt       = col_r;
    rlen_nxt      = rlen_r;
    rbase_nxt     = rbase_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_glyph_nxt = out_glyph_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = ADDR_W'(bottom) * ADDR_W'(DISP_COLS) + ADDR_W'(len_r[bottom]);
    wr_data       = q_head.entry.ch;
    rd_en         = 1'b0;
    rd_addr       = row_base;

    case (state_r)
      S_IDLE: begin
        if (q_head.avail) begin
          q_pop = 1'b1;
          case (q_head.entry.cmd)
            CMD_PRINT: begin
              wr_en = 1'b1;
              if (len_r[bottom] == LEN_W'(DISP_COLS - 1)) begin
                len_nxt[bottom] = LEN_W'(DISP_COLS);
                len_nxt[head_r] = '0;
                head_nxt        = head_inc;
              end else begin
                len_nxt[bottom] = len_r[bottom] + 1'b1;
              end
            end
            CMD_NEWLINE: begin
              len_nxt[head_r] = '0;
              head_nxt        = head_inc;
            end
            CMD_BACK: begin
              if (view_r != '0) begin
                view_nxt = view_r - 1'b1;
              end
            end
            CMD_FWD: begin
              if (view_r != VIEW_W'(TOP_MAX)) begin
                view_nxt = view_r + 1'b1;
              end
            end
            CMD_REFRESH: begin
              state_nxt = S_CLEAR;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_CLEAR;
          out_row_nxt   = 1'b0;
          out_col_nxt   = '0;
          out_glyph_nxt = CH_NUL;
          out_last_nxt  = 1'b0;
          drow_nxt      = '0;
          state_nxt     = S_POS;
        end
      end
      S_POS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_POS;
          out_row_nxt   = 1'(drow_r);
          out_col_nxt   = '0;
          out_glyph_nxt = CH_NUL;
          out_last_nxt  = last_row && (row_len == '0);
          if (row_len != '0) begin
            rd_en     = 1'b1;
            rd_addr   = row_base;
            col_nxt   = '0;
            rlen_nxt  = row_len;
            rbase_nxt = row_base;
            state_nxt = S_CHAR;
          end else if (last_row) begin
            state_nxt = S_IDLE;
          end else begin
            drow_nxt = drow_r + 1'b1;
          end
        end
      end
      S_CHAR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_CHAR;
          out_row_nxt   = 1'(drow_r);
          out_col_nxt   = 4'(col_r);
          out_glyph_nxt = rd_data;
          out_last_nxt  = col_last && last_row;
          if (!col_last) begin
            rd_en   = 1'b1;
            rd_addr = rbase_r + ADDR_W'(col_r) + 1'b1;
            col_nxt = col_r + 1'b1;
          end else if (last_row) begin
            state_nxt = S_IDLE;
          end else begin
            drow_nxt  = drow_r + 1'b1;
            state_nxt = S_POS;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign emit_last = out_free && out_valid_nxt && out_last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      view_r      <= VIEW_W'(TOP_MAX);
      for (int i = 0; i < BUF_LINES; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      view_r      <= view_nxt;
      len_r       <= len_nxt;
    end
    drow_r      <= drow_nxt;
    col_r       <= col_nxt;
    rlen_r      <= rlen_nxt;
    rbase_r     <= rbase_nxt;
    out_kind_r  <= out_kind_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_glyph_r <= out_glyph_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_row    = out_row_r;
  assign out_column = out_col_r;
  assign out_glyph  = out_glyph_r;
  assign out_last   = out_last_r;

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    emit_last |=> state_r == S_IDLE)
    else $error("refresh run continued after its final item");

  a_char_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHAR |-> (rlen_r != '0) && (LEN_W'(col_r) < rlen_r))
    else $error("character walk outside the row length");

  a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r < ROW_W'(BUF_LINES)) && (view_r <= VIEW_W'(TOP_MAX)))
    else $error("ring pointer or view window out of range");

  a_bottom_open: assert property (@(posedge clk) disable iff (!rst_n)
    len_r[bottom] < LEN_W'(DISP_COLS))
    else $error("bottom line full without a scroll");

endmodule
`default_nettype wire

FILE: verif/scrollback_text_console_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module scrollback_text_console_unit_tb;
  import scb_pkg::*;

  // Opcode pattern that the block has no use for, and view move codes
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] DIR_STAY  = 2'b00;
  localparam logic [1:0] DIR_FWD   = 2'b01;
  localparam logic [1:0] DIR_BACK2 = 2'b10;
  localparam logic [1:0] DIR_BACK  = 2'b11;

  // Longest refresh run: clear, then per row a position and a full line
  localparam int RUN_MAX      = 1 + DISP_LINES * (DISP_COLS + 1);
  localparam int RANDOM_ITEMS = 400;
  localparam int TAIL_ITEMS   = 40;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef struct {
    logic [1:0] opcode;
    logic [7:0] character;
    logic [1:0] direction;
    bit         hold_for_drain;
  } console_item_t;

  typedef struct {
    kind_t      kind;
    logic       row;
    logic [3:0] column;
    logic [7:0] glyph;
    logic       last;
  } lcd_cmd_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Block ports; everything the bench drives starts at a known value
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [1:0]        in_opcode    = 2'd0;
  logic [7:0]        in_character = 8'd0;
  logic signed [1:0] in_direction = 2'sd0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [1:0]        out_kind;
  logic              out_row;
  logic [3:0]        out_column;
  logic [7:0]        out_glyph;
  logic              out_last;

  scrollback_text_console_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_character (in_character),
    .in_direction (in_direction),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_row      (out_row),
    .out_column   (out_column),
    .out_glyph    (out_glyph),
    .out_last     (out_last)
  );

  // Items waiting to be sent, and display commands the console still owes
  console_item_t item_q[$];
  lcd_cmd_t      lcd_cmds_due[$];
  bit            console_drained = 1'b1;

  // Shadow of the console state
  logic [7:0] mdl_lines [BUF_LINES][DISP_COLS];
  int         mdl_view;
  int         mdl_cursor;

  int errors          = 0;
  int items_taken     = 0;
  int results_checked = 0;
  int refresh_runs    = 0;
  int longest_run     = 0;
  int cycle_count     = 0;

  // Idling state of each side
  int send_gap    = 0;
  int tx_stretch  = 0;
  bit tx_gappy    = 1'b0;
  int hold_cycles = 0;
  int rx_stretch  = 0;
  bit rx_gappy    = 1'b0;

  task automatic queue_item(input logic [1:0] op, input logic [7:0] ch,
                            input logic [1:0] dir, input bit hold);
    console_item_t it;
    it.opcode         = op;
    it.character      = ch;
    it.direction      = dir;
    it.hold_for_drain = hold;
    item_q.push_back(it);
  endtask

  // Alternate between calm stretches and stretches with idle bursts; drop all
  // idling once the stimulus is nearly spent.
  task automatic roll_idle(inout int stretch, inout bit gappy, input int odds,
                           output int burst);
    burst = 0;
    if (stretch == 0) begin
      gappy   = ($urandom_range(0, 2) != 0);
      stretch = $urandom_range(20, 80);
    end else begin
      stretch--;
    end
    if (gappy && item_q.size() >= TAIL_ITEMS && $urandom_range(1, odds) == 1)
      burst = $urandom_range(1, 14);
  endtask

  // Scroll the store: every line up one, bottom line blank, cursor home
  task automatic scroll_store();
    for (int l = 0; l < BUF_LINES - 1; l++)
      for (int c = 0; c < DISP_COLS; c++)
        mdl_lines[l][c] = mdl_lines[l + 1][c];
    for (int c = 0; c < DISP_COLS; c++)
      mdl_lines[BUF_LINES - 1][c] = CH_NUL;
    mdl_cursor = 0;
  endtask

  // Apply one accepted item to the shadow state; a refresh queues its run of
  // display commands with the final one flagged.
  task automatic predict_console_item(input logic [1:0] op, input logic [7:0] ch,
                                      input logic [1:0] dir);
    lcd_cmd_t run [RUN_MAX];
    int       n;
    int       src;
    n = 0;
    case (op)
      OP_PRINT: begin
        if (ch == CH_NEWLINE) begin
          scroll_store();
        end else if (ch != CH_NUL) begin
          mdl_lines[BUF_LINES - 1][mdl_cursor] = ch;
          mdl_cursor++;
          if (mdl_cursor >= DISP_COLS)
            scroll_store();
        end
      end
      OP_MOVE: begin
        // Sign bit set means a move back, whatever the magnitude
        if (dir[1]) begin
          if (mdl_view > 0)
            mdl_view--;
        end else if (dir == DIR_FWD) begin
          if (mdl_view < TOP_MAX)
            mdl_view++;
        end
      end
      OP_REFRESH: begin
        run[n] = '{KIND_CLEAR, 1'b0, 4'd0, 8'd0, 1'b0};
        n++;
        for (int r = 0; r < DISP_LINES; r++) begin
          src = mdl_view + r;
          run[n] = '{KIND_POS, r[0], 4'd0, 8'd0, 1'b0};
          n++;
          if (src < BUF_LINES) begin
            for (int j = 0; j < DISP_COLS; j++) begin
              if (mdl_lines[src][j] == CH_NUL)
                break;
              run[n] = '{KIND_CHAR, r[0], j[3:0], mdl_lines[src][j], 1'b0};
              n++;
            end
          end
        end
        run[n - 1].last = 1'b1;
        for (int k = 0; k < n; k++)
          lcd_cmds_due.push_back(run[k]);
        refresh_runs++;
        if (n > longest_run)
          longest_run = n;
      end
      default: ;
    endcase
  endtask

  // Driver: present the next item whenever the slot is free. Hold the payload
  // while stalled; insert idle bursts after items; hold back a marked item
  // until the console has delivered everything it owes.
  always @(posedge clk) begin : drv_p
    console_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (item_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (item_q[0].hold_for_drain && (in_valid || !console_drained)) begin
        // The drained flag is registered, so also wait while an item is presented
        in_valid <= 1'b0;
      end else begin
        nxt = item_q.pop_front();
        in_valid     <= 1'b1;
        in_opcode    <= nxt.opcode;
        in_character <= nxt.character;
        in_direction <= nxt.direction;
        roll_idle(tx_stretch, tx_gappy, 3, send_gap);
      end
    end
  end

  // Monitor: predict on every accepted item, check every accepted result
  // against the oldest owed command, then decide the receiver's stall.
  always @(posedge clk) begin : mon_p
    lcd_cmd_t due;
    int       burst;
    if (!rst_n) begin
      for (int l = 0; l < BUF_LINES; l++)
        for (int c = 0; c < DISP_COLS; c++)
          mdl_lines[l][c] = CH_NUL;
      mdl_view   = TOP_MAX;
      mdl_cursor = 0;
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_console_item(in_opcode, in_character, in_direction);
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        if (lcd_cmds_due.size() == 0) begin
          $error("result with nothing owed: kind %0d row %0d column %0d glyph %0h last %0d",
                 out_kind, out_row, out_column, out_glyph, out_last);
          errors++;
        end else begin
          due = lcd_cmds_due.pop_front();
          if (out_kind !== due.kind) begin
            $error("kind: expected %0d, actual %0d", due.kind, out_kind);
            errors++;
          end
          if (out_row !== due.row) begin
            $error("row: expected %0d, actual %0d", due.row, out_row);
            errors++;
          end
          if (out_column !== due.column) begin
            $error("column: expected %0d, actual %0d", due.column, out_column);
            errors++;
          end
          if (out_glyph !== due.glyph) begin
            $error("glyph: expected %0h, actual %0h", due.glyph, out_glyph);
            errors++;
          end
          if (out_last !== due.last) begin
            $error("last: expected %0d, actual %0d", due.last, out_last);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        roll_idle(rx_stretch, rx_gappy, 5, burst);
        out_stall <= (burst > 0);
        if (burst > 0)
          hold_cycles = burst - 1;
      end
    end
    console_drained <= (lcd_cmds_due.size() == 0);
  end

  // Watchdog: give up well beyond the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d commands still owed",
               cycle_count, lcd_cmds_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stim_p
    int counted;
    int sel;
    int pick;
    console_item_t it;

    // Directed: saturate at the newest lines, refresh an empty view
    queue_item(OP_MOVE, 8'h00, DIR_FWD, 1'b0);
    queue_item(OP_REFRESH, 8'h00, DIR_STAY, 1'b0);
    // A zero character is dropped without touching the cursor
    queue_item(OP_PRINT, CH_NUL, DIR_BACK, 1'b0);
    // Fill one line completely: walking one, then walking zero
    for (int k = 0; k < DISP_COLS; k++) begin
      if (k < 8)
        queue_item(OP_PRINT, 8'h01 << k, DIR_STAY, 1'b0);
      else
        queue_item(OP_PRINT, 8'hFF ^ (8'h01 << (k - 8)), DIR_STAY, 1'b0);
    end
    // Short line ended by a newline
    queue_item(OP_PRINT, 8'hFF, DIR_STAY, 1'b0);
    queue_item(OP_PRINT, CH_NEWLINE, DIR_STAY, 1'b0);
    // Bring the full line into view and refresh it
    queue_item(OP_MOVE, 8'hFF, DIR_BACK, 1'b0);
    queue_item(OP_REFRESH, 8'h00, DIR_STAY, 1'b0);
    // Walk back through the raw pattern two, saturate at the oldest line
    queue_item(OP_MOVE, 8'h00, DIR_BACK2, 1'b0);
    queue_item(OP_MOVE, 8'h00, DIR_BACK, 1'b0);
    queue_item(OP_MOVE, 8'h00, DIR_BACK, 1'b0);
    queue_item(OP_MOVE, 8'h00, DIR_STAY, 1'b0);
    queue_item(OP_UNUSED, 8'hFF, DIR_BACK, 1'b0);
    queue_item(OP_REFRESH, 8'hFF, DIR_BACK, 1'b0);

    // Random: mostly printable text with newlines, moves and refreshes,
    // with some raw bytes, zero characters and the unused opcode as noise.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      it.character      = 8'($urandom_range(0, 255));
      it.direction      = 2'($urandom_range(0, 3));
      it.hold_for_drain = (counted == 0) || (counted == RANDOM_ITEMS / 2);
      if (sel < 58) begin
        it.opcode = OP_PRINT;
        pick = $urandom_range(0, 99);
        if (pick < 80)
          it.character = 8'($urandom_range(8'h20, 8'h7E));
        else if (pick < 88)
          it.character = CH_NEWLINE;
        else if (pick < 92)
          it.character = CH_NUL;
      end else if (sel < 78) begin
        it.opcode = OP_MOVE;
      end else if (sel < 94) begin
        it.opcode = OP_REFRESH;
      end else begin
        it.opcode = OP_UNUSED;
      end
      item_q.push_back(it);
      counted++;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to go in, then for every owed command to come out
    while (item_q.size() != 0 || in_valid)
      @(posedge clk);
    while (lcd_cmds_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d items, %0d refreshes (longest run %0d commands)",
             items_taken, refresh_runs, longest_run);
    $display("%0d display commands checked, %0d mismatches", results_checked, errors);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
rtl/scb_pkg.sv
rtl/scb_ram.sv
rtl/scb_front.sv
rtl/scb_queue.sv
rtl/scb_back.sv
rtl/scrollback_text_console_unit.sv
verif/scrollback_text_console_unit_tb.sv
